// File: src/msh_pkg.sv
// Shared constants, types and control structs for the mid/side highpass block.
package msh_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 16;
    localparam int COEF_BITS     = 16;

    // lowpass state holds side << FRACTION_BITS
    localparam int LP_BITS  = SAMPLE_BITS + 1 + FRACTION_BITS;
    localparam int X_BITS   = LP_BITS + 1;
    localparam int ERR_BITS = FRACTION_BITS + 2;

    // golden ratio complement, 25033 / 2^16
    localparam int GOLD_SHIFT = 16;
    localparam logic [GOLD_SHIFT-1:0] GOLD_NEW = GOLD_SHIFT'(25033);

    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;
    localparam int INDEX_BITS = ADDR_BITS - 2;
    localparam logic [INDEX_BITS-1:0] REG_SIDE_COEF = INDEX_BITS'(0);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [X_BITS-1:0]      xval_t;
    typedef logic [COEF_BITS-1:0]          coef_t;

    typedef struct packed {
        logic advance;
        logic phase;
    } step_ctrl_t;

endpackage

// File: src/msh_stream_if.sv
// Stream interfaces for input frames and result frames.
interface msh_in_if;
    logic             valid;
    logic             ready;
    msh_pkg::sample_t left_in;
    msh_pkg::sample_t right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface msh_out_if;
    logic             valid;
    logic             ready;
    msh_pkg::sample_t left_out;
    msh_pkg::sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// File: src/mid_side_highpass_stereo.sv
// Top level: stereo side highpass with noise-shaped requantization.
//
// Frames enter on the audio channel (valid/ready, left_in and right_in, 24-bit
// signed) and leave on the processed channel (left_out, right_out, saturated).
// Every frame yields exactly one result frame, in order.
// The path has three registers: an input register, the rebuilt left/right
// values after the side lowpass multiply, and the result register after the
// noise-shaping multiply, and each frame passes through them in that order.
// Throughput is one frame per cycle; each stage moves whenever the stage after
// it is empty or emptying, so a stalled receiver first fills the bubbles and
// only then pulls audio.ready low. Three frames can be held in flight.
// The side coefficient is written over the APB port at byte address 0 (Q0.16,
// low 16 bits of pwdata); write it only while no frame is in flight.
// Reset clears the coefficient, both side lowpass states and all four shaping
// error states, and selects the even state set for the first frame.
module mid_side_highpass_stereo (
    input  logic                               clk,
    input  logic                               rst_n,
    msh_in_if.sink                             audio,
    msh_out_if.source                          processed,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msh_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [msh_pkg::DATA_BITS-1:0]      pwdata,
    output logic [msh_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s2_valid_reg;
    logic                s2_valid_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                phase_reg;
    logic                phase_next;
    logic                s2_phase_reg;
    logic                s2_phase_next;
    msh_pkg::coef_t      coef_reg;
    msh_pkg::coef_t      coef_next;
    msh_pkg::sample_t    left_reg;
    msh_pkg::sample_t    right_reg;
    logic                accept;
    logic                adv1;
    logic                adv2;
    logic                s1_free;
    logic                s2_free;
    logic                out_free;
    logic                cfg_write;
    logic                coef_hit;
    msh_pkg::step_ctrl_t filt_ctrl;
    msh_pkg::step_ctrl_t shape_ctrl;
    msh_pkg::xval_t      x_left;
    msh_pkg::xval_t      x_right;

    // stage advance chain, from the result side back to the input
    always_comb
    begin
        out_free = !out_valid_reg || processed.ready;
        adv2     = s2_valid_reg && out_free;
        s2_free  = !s2_valid_reg || adv2;
        adv1     = s1_valid_reg && s2_free;
        s1_free  = !s1_valid_reg || adv1;
        accept   = audio.valid && s1_free;

        s1_valid_next  = accept || (s1_valid_reg && !adv1);
        s2_valid_next  = adv1 || (s2_valid_reg && !adv2);
        out_valid_next = adv2 || (out_valid_reg && !processed.ready);
        phase_next     = adv1 ? !phase_reg : phase_reg;
        s2_phase_next  = adv1 ? phase_reg : s2_phase_reg;

        filt_ctrl.advance  = adv1;
        filt_ctrl.phase    = phase_reg;
        shape_ctrl.advance = adv2;
        shape_ctrl.phase   = s2_phase_reg;
    end

    assign audio.ready     = s1_free;
    assign processed.valid = out_valid_reg;

    // configuration port
    always_comb
    begin
        coef_hit  = paddr[msh_pkg::ADDR_BITS-1:2] == msh_pkg::REG_SIDE_COEF;
        cfg_write = psel && penable && pwrite;
        coef_next = (cfg_write && coef_hit) ? pwdata[msh_pkg::COEF_BITS-1:0] : coef_reg;
        prdata    = coef_hit ? msh_pkg::DATA_BITS'(coef_reg) : '0;
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b1;
            s2_phase_reg  <= 1'b1;
            coef_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            s2_phase_reg  <= s2_phase_next;
            coef_reg      <= coef_next;
        end
    end

    // input register, loaded on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= audio.left_in;
            right_reg <= audio.right_in;
        end
    end

    msh_side_filter u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (filt_ctrl),
        .left    (left_reg),
        .right   (right_reg),
        .coef    (coef_reg),
        .x_left  (x_left),
        .x_right (x_right)
    );

    msh_noise_shaper u_shape_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (shape_ctrl),
        .x      (x_left),
        .sample (processed.left_out)
    );

    msh_noise_shaper u_shape_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (shape_ctrl),
        .x      (x_right),
        .sample (processed.right_out)
    );

    a_phase_flips: assert property (@(posedge clk) disable iff (!rst_n)
        adv1 |=> phase_reg != $past(phase_reg))
        else $error("phase did not flip after a filter step");

    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv1 |=> $stable(phase_reg))
        else $error("phase changed without a filter step");

    a_stage2_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_valid_reg))
        else $error("stage 2 filled with no frame in the input register");

    a_shape_phase: assert property (@(posedge clk) disable iff (!rst_n)
        adv1 |=> s2_phase_reg == $past(phase_reg))
        else $error("shaping phase does not follow the filter phase");

endmodule

// File: src/msh_side_filter.sv
// Mid/side split, one-pole side highpass and left/right rebuild, registered.
module msh_side_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  msh_pkg::step_ctrl_t ctrl,
    input  msh_pkg::sample_t    left,
    input  msh_pkg::sample_t    right,
    input  msh_pkg::coef_t      coef,
    output msh_pkg::xval_t      x_left,
    output msh_pkg::xval_t      x_right
);

    localparam int LPW = msh_pkg::LP_BITS;
    localparam int FB  = msh_pkg::FRACTION_BITS;
    localparam int CB  = msh_pkg::COEF_BITS;
    localparam int SB  = msh_pkg::SAMPLE_BITS;
    localparam int PW  = LPW + CB + 2;
    localparam logic signed [PW-1:0] ROUND = PW'(1) << (CB - 1);

    logic signed [LPW-1:0] lp_even_reg;
    logic signed [LPW-1:0] lp_odd_reg;
    logic signed [LPW-1:0] lp_cur;
    logic signed [LPW-1:0] lp_next;
    logic signed [SB:0]    mid;
    logic signed [SB:0]    side;
    logic signed [LPW-1:0] side_f;
    logic signed [LPW-1:0] mid_f;
    logic signed [LPW:0]   diff;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  prod_rnd;
    logic signed [LPW+1:0] step;
    logic signed [LPW+1:0] lp_sum;
    logic signed [LPW:0]   hp;
    logic signed [LPW+1:0] sum_l;
    logic signed [LPW+1:0] sum_r;
    msh_pkg::xval_t        x_left_reg;
    msh_pkg::xval_t        x_right_reg;
    msh_pkg::xval_t        x_left_next;
    msh_pkg::xval_t        x_right_next;

    always_comb
    begin
        mid      = (SB + 1)'(left) + (SB + 1)'(right);
        side     = (SB + 1)'(left) - (SB + 1)'(right);
        side_f   = {side, {FB{1'b0}}};
        mid_f    = {mid, {FB{1'b0}}};
        lp_cur   = ctrl.phase ? lp_even_reg : lp_odd_reg;
        diff     = (LPW + 1)'(side_f) - (LPW + 1)'(lp_cur);
        prod     = PW'(diff) * PW'($signed({1'b0, coef}));
        prod_rnd = prod + ROUND;
        step     = prod_rnd[PW-1:CB];
        lp_sum   = (LPW + 2)'(lp_cur) + step;
        lp_next  = lp_sum[LPW-1:0];
        hp       = (LPW + 1)'(side_f) - (LPW + 1)'(lp_next);
        sum_l    = (LPW + 2)'(mid_f) + (LPW + 2)'(hp);
        sum_r    = (LPW + 2)'(mid_f) - (LPW + 2)'(hp);
        x_left_next  = sum_l[LPW+1:1];
        x_right_next = sum_r[LPW+1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_even_reg <= '0;
            lp_odd_reg  <= '0;
        end
        else if (ctrl.advance)
        begin
            if (ctrl.phase)
            begin
                lp_even_reg <= lp_next;
            end
            else
            begin
                lp_odd_reg <= lp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            x_left_reg  <= x_left_next;
            x_right_reg <= x_right_next;
        end
    end

    assign x_left  = x_left_reg;
    assign x_right = x_right_reg;

endmodule

// File: src/msh_noise_shaper.sv
// Error-feedback requantizer for one channel, with saturation and a result register.
module msh_noise_shaper (
    input  logic                clk,
    input  logic                rst_n,
    input  msh_pkg::step_ctrl_t ctrl,
    input  msh_pkg::xval_t      x,
    output msh_pkg::sample_t    sample
);

    localparam int XW = msh_pkg::X_BITS;
    localparam int FB = msh_pkg::FRACTION_BITS;
    localparam int EW = msh_pkg::ERR_BITS;
    localparam int SB = msh_pkg::SAMPLE_BITS;
    localparam int GS = msh_pkg::GOLD_SHIFT;
    localparam int PW = EW + 1 + GS + 1;
    localparam int QW = XW + 1 - FB;
    localparam logic signed [XW:0]   HALF   = (XW + 1)'(1) << (FB - 1);
    localparam logic signed [FB:0]   E_HALF = {2'b01, {(FB - 1){1'b0}}};
    localparam logic signed [PW-1:0] ROUND  = PW'(1) << (GS - 1);
    localparam logic signed [QW-1:0] QMAX   = QW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] QMIN   = -QMAX - QW'(1);

    logic signed [EW-1:0] err_even_reg;
    logic signed [EW-1:0] err_odd_reg;
    logic signed [EW-1:0] err_cur;
    logic signed [EW-1:0] err_next;
    logic signed [XW:0]   xh;
    logic signed [FB:0]   e;
    logic signed [EW:0]   ediff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_rnd;
    logic signed [EW+1:0] gstep;
    logic signed [EW+1:0] err_sum;
    logic signed [XW:0]   osum;
    logic signed [QW-1:0] oq;
    msh_pkg::sample_t     sample_reg;
    msh_pkg::sample_t     sample_next;

    always_comb
    begin
        err_cur  = ctrl.phase ? err_even_reg : err_odd_reg;
        // quantization error is the rounded-off fraction
        xh       = (XW + 1)'(x) + HALF;
        e        = $signed({1'b0, xh[FB-1:0]}) - E_HALF;
        ediff    = (EW + 1)'(e) - (EW + 1)'(err_cur);
        prod     = PW'(ediff) * PW'($signed({1'b0, msh_pkg::GOLD_NEW}));
        prod_rnd = prod + ROUND;
        gstep    = prod_rnd[PW-1:GS];
        err_sum  = (EW + 2)'(err_cur) + gstep;
        err_next = err_sum[EW-1:0];
        osum     = (XW + 1)'(x) + (XW + 1)'(err_next) + HALF;
        oq       = osum[XW:FB];
        priority if (oq > QMAX)
        begin
            sample_next = QMAX[SB-1:0];
        end
        else if (oq < QMIN)
        begin
            sample_next = QMIN[SB-1:0];
        end
        else
        begin
            sample_next = oq[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_even_reg <= '0;
            err_odd_reg  <= '0;
        end
        else if (ctrl.advance)
        begin
            if (ctrl.phase)
            begin
                err_even_reg <= err_next;
            end
            else
            begin
                err_odd_reg <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule
